/* rtl/core/assert_macros.svh */
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`endif

/* rtl/core/mips_exe_pkg.sv */
// ----------------------------------------------------------------------------
// mips_exe_pkg
// shared types and constants of the execute unit
// ----------------------------------------------------------------------------
`default_nettype none
package mips_exe_pkg;
  localparam int unsigned NumRegs = 32;
  localparam int unsigned RegW    = 32;

  localparam logic [1:0] KindR = 2'd0;
  localparam logic [1:0] KindJ = 2'd1;
  localparam logic [1:0] KindI = 2'd2;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StOvf   = 2'd1;
  localparam logic [1:0] StDivZ  = 2'd2;
  localparam logic [1:0] StUnsup = 2'd3;

  localparam logic [5:0] FnSll  = 6'h00;
  localparam logic [5:0] FnSrl  = 6'h02;
  localparam logic [5:0] FnJr   = 6'h08;
  localparam logic [5:0] FnMfhi = 6'h10;
  localparam logic [5:0] FnMflo = 6'h12;
  localparam logic [5:0] FnMult = 6'h18;
  localparam logic [5:0] FnDiv  = 6'h1A;
  localparam logic [5:0] FnAdd  = 6'h20;
  localparam logic [5:0] FnSub  = 6'h22;
  localparam logic [5:0] FnAnd  = 6'h24;
  localparam logic [5:0] FnOr   = 6'h25;
  localparam logic [5:0] FnXor  = 6'h26;
  localparam logic [5:0] FnSlt  = 6'h2A;

  localparam logic [5:0] OpJ     = 6'h02;
  localparam logic [5:0] OpJal   = 6'h03;
  localparam logic [5:0] OpBeq   = 6'h04;
  localparam logic [5:0] OpBne   = 6'h05;
  localparam logic [5:0] OpBlez  = 6'h06;
  localparam logic [5:0] OpBgtz  = 6'h07;
  localparam logic [5:0] OpAddi  = 6'h08;
  localparam logic [5:0] OpAddiu = 6'h09;
  localparam logic [5:0] OpLui   = 6'h0F;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [1:0]  kind;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic [1:0]  status;
  } out_item_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

/* rtl/core/mips_subset_execute_unit.sv */
// ----------------------------------------------------------------------------
// mips_subset_execute_unit
// executes one mips32 integer instruction word per item
// ----------------------------------------------------------------------------
// One item at a time. Register file is two synchronous RAM copies (one per
// source port) with registered read. Most instructions pass from accept
// through read and execute (with write back) to the result register; MULT
// also passes a multiply state, as the 32x32 product is registered before
// HI/LO update; DIV waits on the one-bit-per-cycle divider loop. The result
// register frees the input side as soon as it is taken. A reset clears the
// register file by a sweep over all NumRegs entries, accepting no item.
`default_nettype none
module mips_subset_execute_unit #(
  parameter int unsigned NumRegs = mips_exe_pkg::NumRegs
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire mips_exe_pkg::in_item_t  in_item_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output mips_exe_pkg::out_item_t      out_item_o
);
  import mips_exe_pkg::*;

  localparam int unsigned AW = $clog2(NumRegs);

  typedef enum logic [2:0] {
    SClear, SIdle, SRead, SExec, SMul, SDiv, SOut
  } state_e;

  state_e      state_q;
  logic [AW:0] clr_q;
  logic [31:0] iw_q, pc_q, hi_q, lo_q;
  logic [1:0]  kind_q;
  logic [63:0] prod_q;
  logic        na_q, nb_q;
  out_item_t   res_q, res_d;
  logic        ov_q;

  // register file write port shared by clear sweep and write back
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata, ra_raw, rb_raw, a, b;

  logic accept;
  assign accept     = (state_q == SIdle) && in_valid_i;
  assign in_stall_o = (state_q != SIdle);

  // read addresses follow the accepted item, not the live input
  logic [AW-1:0] raddr_a, raddr_b;
  assign raddr_a = accept ? in_item_i.instr_word[21+:AW] : iw_q[21+:AW];
  assign raddr_b = accept ? in_item_i.instr_word[16+:AW] : iw_q[16+:AW];

  mips_exe_ram #(.Width(32), .Depth(NumRegs)) u_ram_a (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr_a), .rdata_o(ra_raw)
  );
  mips_exe_ram #(.Width(32), .Depth(NumRegs)) u_ram_b (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr_b), .rdata_o(rb_raw)
  );

  // decoded fields
  logic [4:0]  rs, rt, rd, sh;
  logic [5:0]  fn, op;
  logic [31:0] simm, pc4, sum, dif, sumi, btgt, jtgt, srl, sll, rot;
  assign rs   = iw_q[25:21];
  assign rt   = iw_q[20:16];
  assign rd   = iw_q[15:11];
  assign sh   = iw_q[10:6];
  assign fn   = iw_q[5:0];
  assign op   = iw_q[31:26];
  assign a    = (rs == 5'd0) ? 32'd0 : ra_raw;
  assign b    = (rt == 5'd0) ? 32'd0 : rb_raw;
  assign simm = {{16{iw_q[15]}}, iw_q[15:0]};
  assign pc4  = pc_q + 32'd4;
  assign sum  = a + b;
  assign dif  = a - b;
  assign sumi = a + simm;
  assign btgt = pc4 + {simm[29:0], 2'b00};
  assign jtgt = {pc4[31:28], iw_q[25:0], 2'b00};
  assign srl  = b >> sh;
  assign sll  = b << sh;
  assign rot  = srl | ((sh == 5'd0) ? 32'd0 : (b << (6'd32 - {1'b0, sh})));

  div_req_t dreq;
  div_rsp_t drsp;
  mips_exe_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // execute decode
  logic       wr, is_mul, is_div;
  logic [4:0] didx;
  logic [31:0] dval, npc;
  logic [1:0] st;
  always_comb begin
    wr = 1'b0; didx = rd; dval = 32'd0; npc = pc4; st = StOk;
    is_mul = 1'b0; is_div = 1'b0;
    case (kind_q)
      KindR: begin
        case (fn)
          FnAdd: if (((a ^ sum) & (b ^ sum)) >> 31 != 0) st = StOvf;
                 else begin wr = 1'b1; dval = sum; end
          FnSub: if (((a ^ b) & (a ^ dif)) >> 31 != 0) st = StOvf;
                 else begin wr = 1'b1; dval = dif; end
          FnAnd:  begin wr = 1'b1; dval = a & b; end
          FnOr:   begin wr = 1'b1; dval = a | b; end
          FnXor:  begin wr = 1'b1; dval = a ^ b; end
          FnSlt:  begin wr = 1'b1; dval = {31'd0, $signed(a) < $signed(b)}; end
          FnSll:  begin wr = 1'b1; dval = sll; end
          FnSrl:  begin wr = 1'b1; dval = iw_q[21] ? rot : srl; end
          FnMult: is_mul = 1'b1;
          FnDiv:  if (b == 32'd0) st = StDivZ; else is_div = 1'b1;
          FnMfhi: begin wr = 1'b1; dval = hi_q; end
          FnMflo: begin wr = 1'b1; dval = lo_q; end
          FnJr:   npc = a;
          default: st = StUnsup;
        endcase
      end
      KindJ: begin
        case (op)
          OpJ:   npc = jtgt;
          OpJal: begin npc = jtgt; wr = 1'b1; didx = 5'd31; dval = pc4; end
          default: st = StUnsup;
        endcase
      end
      KindI: begin
        didx = rt;
        case (op)
          OpAddi: if (((a ^ sumi) & (simm ^ sumi)) >> 31 != 0) st = StOvf;
                  else begin wr = 1'b1; dval = sumi; end
          OpAddiu: begin wr = 1'b1; dval = sumi; end
          OpLui:   begin wr = 1'b1; dval = {iw_q[15:0], 16'd0}; end
          OpBeq:   if (a == b) npc = btgt;
          OpBne:   if (a != b) npc = btgt;
          OpBlez:  if (a == 32'd0 || a[31]) npc = btgt;
          OpBgtz:  if (a != 32'd0 && !a[31]) npc = btgt;
          default: st = StUnsup;
        endcase
      end
      default: st = StUnsup;
    endcase
    if (!wr || didx == 5'd0) begin
      wr = 1'b0; didx = 5'd0; dval = 32'd0;
    end
    res_d = '{next_pc: npc, reg_written: wr, dest_index: didx,
              dest_value: dval, status: st};
  end

  assign dreq.start    = (state_q == SExec) && is_div;
  assign dreq.dividend = a[31] ? 32'd0 - a : a;
  assign dreq.divisor  = b[31] ? 32'd0 - b : b;

  assign we    = (state_q == SClear) || ((state_q == SExec) && res_d.reg_written);
  assign waddr = (state_q == SClear) ? clr_q[AW-1:0] : res_d.dest_index[AW-1:0];
  assign wdata = (state_q == SClear) ? 32'd0 : res_d.dest_value;

  // sequencer with state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      clr_q   <= '0;
      pc_q    <= '0;
      hi_q    <= '0;
      lo_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      case (state_q)
        SClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (AW+1)'(NumRegs - 1)) state_q <= SIdle;
        end
        SIdle: if (accept) state_q <= SRead;
        SRead: state_q <= SExec;
        SExec: begin
          pc_q <= res_d.next_pc;
          if (is_mul) state_q <= SMul;
          else if (is_div) state_q <= SDiv;
          else begin ov_q <= 1'b1; state_q <= SOut; end
        end
        SMul: begin
          {hi_q, lo_q} <= prod_q;
          ov_q <= 1'b1; state_q <= SOut;
        end
        SDiv: if (drsp.done) begin
          lo_q <= (na_q != nb_q) ? 32'd0 - drsp.quot : drsp.quot;
          hi_q <= na_q ? 32'd0 - drsp.rem : drsp.rem;
          ov_q <= 1'b1; state_q <= SOut;
        end
        SOut: if (!out_stall_i) begin ov_q <= 1'b0; state_q <= SIdle; end
        default: state_q <= SIdle;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      iw_q   <= in_item_i.instr_word;
      kind_q <= in_item_i.kind;
    end
    if (state_q == SExec) begin
      res_q  <= res_d;
      prod_q <= 64'($signed(a) * $signed(b));
      na_q   <= a[31];
      nb_q   <= b[31];
    end
  end

  assign out_valid_o = ov_q;
  assign out_item_o  = res_q;
endmodule
`default_nettype wire

/* rtl/core/mips_exe_ram.sv */
// ----------------------------------------------------------------------------
// mips_exe_ram
// generic single-port write, single-port read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module mips_exe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* rtl/core/mips_exe_div.sv */
// ----------------------------------------------------------------------------
// mips_exe_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module mips_exe_div (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire mips_exe_pkg::div_req_t req_i,
  output mips_exe_pkg::div_rsp_t      rsp_o
);
  import mips_exe_pkg::*;

  logic [31:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[31:0], quot_q[31]} - {1'b0, dvs_q};
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 6'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one dividend bit and try a subtract
      if (!trial[32]) begin
        rem_d = trial;
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], quot_q[31]};
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q[31:0];
endmodule
`default_nettype wire

/* rtl/core/mips_exe_checker.sv */
// ----------------------------------------------------------------------------
// mips_exe_checker
// port-level checks of the execute unit, bound into mips_subset_execute_unit
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module mips_exe_checker (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_o,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire mips_exe_pkg::out_item_t out_item_o
);
  import mips_exe_pkg::*;

  // a held result keeps its payload
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, ##1 $stable(out_item_o), "result changed while stalled")
  // no write is reported without a destination
  `ASSERT_ALWAYS(a_dest, clk_i, rst_ni, !out_valid_o || (out_item_o.reg_written == (out_item_o.dest_index != 5'd0)), "write flag and index disagree")
  // a faulting item never writes
  `ASSERT_ALWAYS(a_fault, clk_i, rst_ni, !out_valid_o || out_item_o.status == StOk || !out_item_o.reg_written, "fault with write")
  // one item at a time: input blocked while a result waits
  `ASSERT_ALWAYS(a_one, clk_i, rst_ni, !out_valid_o || in_stall_o, "input open with result pending")
  // an accepted item blocks the input next cycle
  `ASSERT_IMPL(a_acc, clk_i, rst_ni, in_valid_i && !in_stall_o, ##1 in_stall_o, "second item accepted")
endmodule

bind mips_subset_execute_unit mips_exe_checker u_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_item_o
);
`default_nettype wire
